// File: design/pcpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpm_pkg
// Shared types, codes and reset values of the packet-commanded PWM motor node.
// ----------------------------------------------------------------------------
package pcpm_pkg;

	// Event kinds carried in the input tuser field.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_BYTE  = 2'd1,
		OP_PULSE = 2'd2
	} op_t;

	// Packet command codes (low nibble of the header byte).
	localparam logic [3:0] CMD_LOAD_COUNT = 4'd1;
	localparam logic [3:0] CMD_MOTOR_DUTY = 4'd2;
	localparam logic [3:0] CMD_DIRECTION  = 4'd3;
	localparam logic [3:0] CMD_HEAT1_DUTY = 4'd4;
	localparam logic [3:0] CMD_HEAT2_DUTY = 4'd5;
	localparam logic [3:0] CMD_RUN        = 4'd6;

	// Command code placed in the report header.
	localparam logic [3:0] REPORT_CMD = 4'd1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_NODE_ADDR   = 2'd0;
	localparam logic [1:0] CFG_REPORT_ADDR = 2'd1;
	localparam logic [1:0] CFG_PWM_PERIOD  = 2'd2;

	// Reset values.
	localparam logic [3:0] RST_NODE_ADDR   = 4'd11;
	localparam logic [3:0] RST_REPORT_ADDR = 4'd13;
	localparam logic [7:0] RST_PWM_PERIOD  = 8'd100;
	localparam logic [7:0] RST_MOTOR_DUTY  = 8'd50;

	// One result item.
	typedef struct packed {
		logic       heat1;
		logic       heat2;
		logic       motor_right;
		logic       motor_left;
		logic       run;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
	} res_t;

	// What the core hands to the output queue for one item.
	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} core_out_t;

	// Configuration write request.
	typedef struct packed {
		logic       we;
		logic [1:0] index;
		logic [7:0] data;
	} cfg_wr_t;

endpackage
`default_nettype wire

// File: design/packet_commanded_pwm_motor_node_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packet_commanded_pwm_motor_node_unit
// Packet-commanded PWM motor node: PWM pins, serial command packets and
// revolution count reports.
// ----------------------------------------------------------------------------
// Each input item is one event, selected by s_tuser: a PWM tick, a received
// serial byte in s_tdata, or a revolution pulse. A tick, a byte or an unused
// code yields one result item; a pulse yields two, the report header and then
// the remaining revolution count, both with tx_valid set in m_tuser and
// m_tlast on the second. Items enter an input register, are applied to the
// node state once the queue has room for all their results and land in a
// two-entry result queue. Ticks and bytes sustain one item per cycle while
// m_tready stays high; a pulse occupies two queue slots and the single queue
// read port drains one item per cycle, so a pulse waits until both slots are
// free. Configuration writes through cfg_we, cfg_index and cfg_wdata take
// effect at the next clock edge and are meant to happen only while the block
// is idle; an index beyond the register list is ignored.
// ----------------------------------------------------------------------------
module packet_commanded_pwm_motor_node_unit
	import pcpm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input items.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] operation
	// Result items.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [0] heater_one_pwm, [1] heater_two_pwm,
	                                    // [2] motor_right_pwm, [3] motor_left_pwm,
	                                    // [4] run_enable, [12:5] tx_byte, [15:13] zero
	output logic [0:0]       m_tuser,   // [0] tx_valid
	output logic             m_tlast,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_wdata
);

	// Input register stage.
	logic       in_valid_s1;
	logic [1:0] op_s1;
	logic [7:0] byte_s1;

	logic       accept, fire;
	logic [1:0] free;
	core_out_t  core_res;
	cfg_wr_t    cfg;
	res_t       out_res;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_wdata};

	// The held item is applied once the queue has room for all its results.
	assign fire     = in_valid_s1 && (core_res.count <= free);
	assign s_tready = !in_valid_s1 || fire;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (accept) begin
			in_valid_s1 <= 1'b1;
		end else if (fire) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	pcpm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (fire),
		.op      (op_s1),
		.rx_byte (byte_s1),
		.result  (core_res)
	);

	pcpm_out_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_n      (fire ? core_res.count : 2'd0),
		.push_first  (core_res.first),
		.push_second (core_res.second),
		.free        (free),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (out_res)
	);

	assign m_tdata = {3'd0, out_res.tx_byte, out_res.run, out_res.motor_left,
		out_res.motor_right, out_res.heat2, out_res.heat1};
	assign m_tuser = out_res.tx_valid;
	assign m_tlast = out_res.last;

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !fire) |=> (in_valid_s1 && $stable(op_s1) && $stable(byte_s1)))
		else $error("held item lost while the result queue was full");

	a_fire_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> in_valid_s1)
		else $error("core applied without a held item");

	a_pulse_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == OP_PULSE) |-> (free == 2'd2))
		else $error("pulse applied without room for both report items");

endmodule
`default_nettype wire

// File: design/pcpm_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpm_core
// Node state, configuration registers and the per-item update logic.
// ----------------------------------------------------------------------------
module pcpm_core
	import pcpm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_wr_t   cfg,
	input  wire logic      fire,
	input  wire logic [1:0] op,
	input  wire logic [7:0] rx_byte,
	output core_out_t      result
);

	logic [3:0] node_addr_q, rep_addr_q;
	logic [7:0] period_q;
	logic [7:0] pwm_count_q, heat1_duty_q, heat2_duty_q, motor_duty_q, rev_count_q;
	logic       dir_left_q, run_q, await_q;
	logic [3:0] pend_cmd_q, pins_q;

	logic [7:0] pwm_count_n, heat1_duty_n, heat2_duty_n, motor_duty_n, rev_count_n;
	logic       dir_left_n, run_n, await_n;
	logic [3:0] pend_cmd_n, pins_n;
	logic [7:0] tick_cnt;
	logic       motor_on;

	always_comb begin
		pwm_count_n  = pwm_count_q;
		heat1_duty_n = heat1_duty_q;
		heat2_duty_n = heat2_duty_q;
		motor_duty_n = motor_duty_q;
		rev_count_n  = rev_count_q;
		dir_left_n   = dir_left_q;
		run_n        = run_q;
		await_n      = await_q;
		pend_cmd_n   = pend_cmd_q;
		pins_n       = pins_q;
		tick_cnt     = pwm_count_q + 8'd1;
		if (tick_cnt >= period_q) begin
			tick_cnt = 8'd0;
		end
		motor_on = (tick_cnt < motor_duty_q);

		case (op_t'(op))
			OP_TICK: begin
				pwm_count_n = tick_cnt;
				pins_n = {motor_on & dir_left_q, motor_on & ~dir_left_q,
					tick_cnt < heat2_duty_q, tick_cnt < heat1_duty_q};
			end
			OP_BYTE: begin
				if (!await_q) begin
					if (rx_byte[7:4] == node_addr_q) begin
						pend_cmd_n = rx_byte[3:0];
						await_n    = 1'b1;
					end
				end else begin
					await_n = 1'b0;
					case (pend_cmd_q)
						CMD_LOAD_COUNT: rev_count_n  = rx_byte;
						CMD_MOTOR_DUTY: motor_duty_n = rx_byte;
						CMD_DIRECTION:  dir_left_n   = (rx_byte == 8'd1);
						CMD_HEAT1_DUTY: heat1_duty_n = rx_byte;
						CMD_HEAT2_DUTY: heat2_duty_n = rx_byte;
						CMD_RUN:        run_n        = 1'b1;
						default: ;
					endcase
				end
			end
			OP_PULSE: begin
				rev_count_n = rev_count_q - 8'd1;
				if (rev_count_n == 8'd0) begin
					run_n = 1'b0;
				end
			end
			default: ;
		endcase

		result.first.heat1       = pins_n[0];
		result.first.heat2       = pins_n[1];
		result.first.motor_right = pins_n[2];
		result.first.motor_left  = pins_n[3];
		result.first.run         = run_n;
		if (op == OP_PULSE) begin
			result.count          = 2'd2;
			result.first.tx_valid = 1'b1;
			result.first.tx_byte  = {rep_addr_q, REPORT_CMD};
			result.first.last     = 1'b0;
		end else begin
			result.count          = 2'd1;
			result.first.tx_valid = 1'b0;
			result.first.tx_byte  = 8'd0;
			result.first.last     = 1'b1;
		end
		// The second item of a pulse repeats the pins and carries the count.
		result.second = result.first;
		if (op == OP_PULSE) begin
			result.second.tx_byte = rev_count_n;
			result.second.last    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_addr_q  <= RST_NODE_ADDR;
			rep_addr_q   <= RST_REPORT_ADDR;
			period_q     <= RST_PWM_PERIOD;
			pwm_count_q  <= 8'd0;
			heat1_duty_q <= 8'd0;
			heat2_duty_q <= 8'd0;
			motor_duty_q <= RST_MOTOR_DUTY;
			rev_count_q  <= 8'd0;
			dir_left_q   <= 1'b1;
			run_q        <= 1'b0;
			await_q      <= 1'b0;
			pend_cmd_q   <= 4'd0;
			pins_q       <= 4'd0;
		end else begin
			if (cfg.we) begin
				unique case (cfg.index)
					CFG_NODE_ADDR:   node_addr_q <= cfg.data[3:0];
					CFG_REPORT_ADDR: rep_addr_q  <= cfg.data[3:0];
					CFG_PWM_PERIOD:  period_q    <= cfg.data;
					default: ;
				endcase
			end
			if (fire) begin
				pwm_count_q  <= pwm_count_n;
				heat1_duty_q <= heat1_duty_n;
				heat2_duty_q <= heat2_duty_n;
				motor_duty_q <= motor_duty_n;
				rev_count_q  <= rev_count_n;
				dir_left_q   <= dir_left_n;
				run_q        <= run_n;
				await_q      <= await_n;
				pend_cmd_q   <= pend_cmd_n;
				pins_q       <= pins_n;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/pcpm_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpm_out_queue
// Two-entry result queue that takes one or two items per cycle as room allows.
// ----------------------------------------------------------------------------
module pcpm_out_queue
	import pcpm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic [1:0] push_n,
	input  wire res_t      push_first,
	input  wire res_t      push_second,
	output logic [1:0]     free,
	output logic           out_valid,
	input  wire logic      out_ready,
	output res_t           out_data
);

	res_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop       = out_valid & out_ready;
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	// A slot emptied this cycle can be refilled in the same cycle.
	assign free      = 2'd2 - count_q + {1'b0, pop};

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_first;
		end
		if (push_n == 2'd2) begin
			mem_q[~wr_ptr_q] <= push_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q ^ push_n[0];
			rd_ptr_q <= rd_ptr_q ^ pop;
			count_q  <= count_q + push_n - {1'b0, pop};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result queue count exceeds its depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n <= free)
		else $error("result queue pushed beyond its free space");

	a_pair_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |=> out_valid)
		else $error("result pair pushed but queue shows no item");

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the packet-commanded PWM motor node. Events go
// in as items with random gaps, result items come out against random stalls,
// and a scoreboard class that tracks the node state predicts every result.
// ----------------------------------------------------------------------------
module tb;
	import pcpm_pkg::*;

	// Operation code that the block does not use; it must still answer once.
	localparam logic [1:0] OP_SPARE = 2'd3;
	// Command codes outside the command set, which the node swallows.
	localparam logic [3:0] CMD_NONE = 4'd0;
	localparam logic [3:0] CMD_TOP  = 4'd15;
	// Cycles without any handshake before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 1000;
	// Random items per configuration phase.
	localparam int PHASE_ITEMS = 320;

	// The scoreboard keeps its own copy of the node state and configuration.
	// Every accepted input item is applied to that copy, and the pin levels
	// and report bytes it produces are queued until the block delivers them.
	class motor_node_tracker;
		logic [3:0] node_addr;
		logic [3:0] report_addr;
		logic [7:0] period;
		logic [7:0] pwm_count;
		logic [7:0] heat1_duty;
		logic [7:0] heat2_duty;
		logic [7:0] motor_duty;
		logic [7:0] rev_count;
		logic       dir_left;
		logic       run_flag;
		logic       awaiting;
		logic [3:0] pending_cmd;
		logic [3:0] pins;
		res_t       awaited[$];
		int         mismatches;

		function new();
			node_addr   = RST_NODE_ADDR;
			report_addr = RST_REPORT_ADDR;
			period      = RST_PWM_PERIOD;
			pwm_count   = 8'd0;
			heat1_duty  = 8'd0;
			heat2_duty  = 8'd0;
			motor_duty  = RST_MOTOR_DUTY;
			rev_count   = 8'd0;
			dir_left    = 1'b1;
			run_flag    = 1'b0;
			awaiting    = 1'b0;
			pending_cmd = 4'd0;
			pins        = 4'd0;
			mismatches  = 0;
		endfunction

		function void set_registers(logic [3:0] node, logic [3:0] report, logic [7:0] per);
			node_addr   = node;
			report_addr = report;
			period      = per;
		endfunction

		// Every result carries the pin levels and run flag as they stand now.
		function res_t make_item(logic tx_valid, logic [7:0] tx_byte, logic last);
			res_t r;
			r.heat1       = pins[0];
			r.heat2       = pins[1];
			r.motor_right = pins[2];
			r.motor_left  = pins[3];
			r.run         = run_flag;
			r.tx_valid    = tx_valid;
			r.tx_byte     = tx_byte;
			r.last        = last;
			return r;
		endfunction

		function void apply_command(logic [7:0] data);
			case (pending_cmd)
				CMD_LOAD_COUNT: rev_count = data;
				CMD_MOTOR_DUTY: motor_duty = data;
				CMD_DIRECTION:  dir_left = (data == 8'd1);
				CMD_HEAT1_DUTY: heat1_duty = data;
				CMD_HEAT2_DUTY: heat2_duty = data;
				CMD_RUN:        run_flag = 1'b1;
				default:        ;
			endcase
		endfunction

		function void note_event(logic [1:0] op, logic [7:0] data);
			logic [7:0] next_count;
			logic       motor_on;
			case (op)
				OP_TICK: begin
					// The counter wraps modulo 256 and also whenever it is at or
					// past the period, so a period of zero pins it at zero.
					next_count = pwm_count + 8'd1;
					if (next_count >= period)
						next_count = 8'd0;
					pwm_count = next_count;
					motor_on = (next_count < motor_duty);
					pins = {motor_on & dir_left, motor_on & ~dir_left,
						next_count < heat2_duty, next_count < heat1_duty};
					awaited.push_back(make_item(1'b0, 8'd0, 1'b1));
				end
				OP_BYTE: begin
					// A header for another node is dropped; once a header has
					// been taken, the next byte is data whatever it holds.
					if (!awaiting) begin
						if (data[7:4] == node_addr) begin
							pending_cmd = data[3:0];
							awaiting = 1'b1;
						end
					end else begin
						apply_command(data);
						awaiting = 1'b0;
					end
					awaited.push_back(make_item(1'b0, 8'd0, 1'b1));
				end
				OP_PULSE: begin
					// The count wraps below zero; only a pulse that lands on zero
					// drops the run flag.
					rev_count = rev_count - 8'd1;
					if (rev_count == 8'd0)
						run_flag = 1'b0;
					awaited.push_back(make_item(1'b1, {report_addr, REPORT_CMD}, 1'b0));
					awaited.push_back(make_item(1'b1, rev_count, 1'b1));
				end
				default: begin
					awaited.push_back(make_item(1'b0, 8'd0, 1'b1));
				end
			endcase
		endfunction

		task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
			if (mismatches < 100)
				$display("[%0t] ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
			mismatches++;
		endtask

		task compare_field(string what, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch(what, got, want);
		endtask

		task check_output(logic [15:0] tdata, logic [0:0] tuser, logic tlast);
			res_t want;
			if (awaited.size() == 0) begin
				report_mismatch("item with nothing outstanding", tdata, 16'd0);
				return;
			end
			want = awaited.pop_front();
			compare_field("heater_one_pwm", 16'(tdata[0]), 16'(want.heat1));
			compare_field("heater_two_pwm", 16'(tdata[1]), 16'(want.heat2));
			compare_field("motor_right_pwm", 16'(tdata[2]), 16'(want.motor_right));
			compare_field("motor_left_pwm", 16'(tdata[3]), 16'(want.motor_left));
			compare_field("run_enable", 16'(tdata[4]), 16'(want.run));
			compare_field("tx_byte", 16'(tdata[12:5]), 16'(want.tx_byte));
			compare_field("tdata padding", 16'(tdata[15:13]), 16'd0);
			compare_field("tx_valid", 16'(tuser[0]), 16'(want.tx_valid));
			compare_field("last", 16'(tlast), 16'(want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic [1:0]  s_tuser = OP_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_NODE_ADDR;
	logic [7:0]  cfg_wdata = 8'd0;

	// When set, the matching side runs back to back for a while.
	logic send_steady = 1'b0;
	logic take_steady = 1'b0;
	int   idle_cycles = 0;

	motor_node_tracker tracker = new();

	packet_commanded_pwm_motor_node_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [7:0] rx_byte
		.s_tuser   (s_tuser),   // [1:0] operation
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [0] heater one, [1] heater two, [2] motor right,
		                        // [3] motor left, [4] run_enable, [12:5] tx_byte
		.m_tuser   (m_tuser),   // [0] tx_valid
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Any cycle with a handshake on either side counts as progress; a long
	// stretch without one means the block has hung or lost a result.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("packet_commanded_pwm_motor_node_unit verification failed");
				$finish;
			end
		end
	end

	// Offers one item, waits for the handshake and then draws the gap before
	// the next one. Valid is left high when there is no gap, so it is never
	// dropped and raised again within the same time step.
	task automatic send_event(input logic [1:0] op, input logic [7:0] data);
		int pause;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		tracker.note_event(op, data);
		@(negedge clk);
		if ($urandom_range(0, 79) == 0)
			send_steady = ~send_steady;
		pause = send_steady ? 0 : $urandom_range(0, 12);
		if (pause > 0) begin
			s_tvalid <= 1'b0;
			repeat (pause) @(negedge clk);
		end
	endtask

	// Stops offering items and lets every outstanding result come back. The
	// block answers every item, so once the queue is empty it is idle; the
	// few extra cycles only add margin.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_registers(input logic [3:0] node, input logic [3:0] report,
			input logic [7:0] per);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_NODE_ADDR;
		cfg_wdata <= {4'd0, node};
		@(negedge clk);
		cfg_index <= CFG_REPORT_ADDR;
		cfg_wdata <= {4'd0, report};
		@(negedge clk);
		cfg_index <= CFG_PWM_PERIOD;
		cfg_wdata <= per;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_registers(node, report, per);
	endtask

	// Sends a full packet: header addressed to this node, then the data byte.
	task automatic send_packet(input logic [3:0] cmd, input logic [7:0] data);
		send_event(OP_BYTE, {tracker.node_addr, cmd});
		send_event(OP_BYTE, data);
	endtask

	// Mostly well-formed packets, tick bursts and pulses, with some foreign
	// bytes, unused operations, interleaved events and truncated packets.
	task automatic run_random(input int target);
		int         done_items;
		int         pick;
		logic [3:0] cmd;
		logic [7:0] value;
		done_items = 0;
		while (done_items < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				cmd = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 6));
				case (cmd)
					CMD_LOAD_COUNT: value = $urandom_range(0, 1) ? 8'($urandom_range(0, 4))
						: 8'($urandom_range(0, 255));
					CMD_DIRECTION:  value = $urandom_range(0, 1) ? 8'd1
						: 8'($urandom_range(0, 255));
					default:        value = 8'($urandom_range(0, 255));
				endcase
				send_event(OP_BYTE, {tracker.node_addr, cmd});
				done_items++;
				// Other events between header and data must not disturb the packet.
				if ($urandom_range(0, 9) == 0) begin
					send_event($urandom_range(0, 1) ? OP_TICK : OP_PULSE,
						8'($urandom_range(0, 255)));
					done_items++;
				end
				// Now and then the data byte is left out, so the next byte that
				// arrives completes the packet instead.
				if ($urandom_range(0, 19) != 0) begin
					send_event(OP_BYTE, value);
					done_items++;
				end
			end else if (pick < 70) begin
				repeat ($urandom_range(1, 8)) begin
					send_event(OP_TICK, 8'($urandom_range(0, 255)));
					done_items++;
				end
			end else if (pick < 85) begin
				send_event(OP_PULSE, 8'($urandom_range(0, 255)));
				done_items++;
			end else if (pick < 95) begin
				send_event(OP_BYTE, 8'($urandom_range(0, 255)));
				done_items++;
			end else begin
				send_event(OP_SPARE, 8'($urandom_range(0, 255)));
				done_items++;
			end
		end
	endtask

	// Result side: a random stall before each item, ready held high across
	// back-to-back items, and every accepted item checked at once.
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 79) == 0)
				take_steady = ~take_steady;
			stall = take_steady ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			tracker.check_output(m_tdata, m_tuser, m_tlast);
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset configuration. The first tick shows the
		// reset motor duty on the left pin with the heaters off.
		send_event(OP_TICK, 8'h00);
		send_event(OP_SPARE, 8'hFF);
		// A header meant for another node is dropped and opens no packet.
		send_event(OP_BYTE, {~tracker.node_addr, CMD_RUN});
		send_packet(CMD_HEAT1_DUTY, 8'hFF);
		send_packet(CMD_MOTOR_DUTY, 8'hFF);
		send_packet(CMD_DIRECTION, 8'h00);
		send_event(OP_TICK, 8'hFF);
		// Run with a count of two: the second pulse reaches zero and drops the
		// run flag, the third wraps the count to its top value.
		send_packet(CMD_LOAD_COUNT, 8'd2);
		send_packet(CMD_RUN, 8'h00);
		send_event(OP_PULSE, 8'h00);
		send_event(OP_PULSE, 8'hFF);
		send_event(OP_PULSE, 8'h00);
		// Unknown commands consume their data byte and change nothing.
		send_packet(CMD_NONE, 8'h55);
		send_packet(CMD_TOP, 8'hAA);
		send_packet(CMD_DIRECTION, 8'h01);
		// Loading a zero count leaves the run flag set.
		send_packet(CMD_RUN, 8'h01);
		send_packet(CMD_LOAD_COUNT, 8'h00);
		send_event(OP_TICK, 8'h00);

		// Random phases, each behind a full drain. The first settings hit the register
		// extremes, then a zero period and the reset values; the rest are random.
		for (int phase = 0; phase < 6; phase++) begin
			drain_results();
			case (phase)
				0:       write_registers(4'd0, 4'd15, 8'd1);
				1:       write_registers(4'd15, 4'd0, 8'd255);
				2:       write_registers(4'd6, 4'd9, 8'd0);
				3:       write_registers(RST_NODE_ADDR, RST_REPORT_ADDR, RST_PWM_PERIOD);
				default: write_registers(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					8'($urandom_range(1, 255)));
			endcase
			run_random(PHASE_ITEMS);
		end

		drain_results();
		repeat (16) @(negedge clk);
		if (tracker.mismatches == 0) begin
			$display("packet_commanded_pwm_motor_node_unit verification clean");
		end else begin
			$display("packet_commanded_pwm_motor_node_unit verification failed");
		end
		$finish;
	end

endmodule
